@@ sv/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

  localparam int SEXTET_W = 6;
  localparam int CNT_W    = 3;
  localparam int BUF_W    = 2 * SEXTET_W;

  localparam logic [7:0] PAD_CHAR      = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9  = 8'h39;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_SLASH    = 8'h2F;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCR = 8'h5F;

  localparam logic [SEXTET_W-1:0] LOWER_BASE = 6'd26;
  localparam logic [SEXTET_W-1:0] DIGIT_BASE = 6'd52;
  localparam logic [SEXTET_W-1:0] SEXTET_62  = 6'd62;
  localparam logic [SEXTET_W-1:0] SEXTET_63  = 6'd63;

  localparam logic [CNT_W-1:0] BYTE_BITS = 3'd0;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       last_of_string;
  } b64d_out_t;

  typedef struct packed {
    kind_t                kind;
    logic [SEXTET_W-1:0]  sextet;
    logic                 eos;
  } b64d_entry_t;

endpackage

`default_nettype wire

@@ sv/b64d_front.sv @@
`default_nettype none

module b64d_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  b64d_pkg::b64d_in_t   in_data,
  input  wire                  url_alpha,
  input  wire                  q_full,
  output logic                 q_push,
  output b64d_pkg::b64d_entry_t q_entry
);

  logic [7:0]  ch;
  logic        hit_62;
  logic        hit_63;
  logic        beat_seen_r;
  logic        beat_seen_nxt;

  assign ch       = in_data.char_in;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    hit_62 = url_alpha ? (ch == b64d_pkg::CHAR_MINUS) : (ch == b64d_pkg::CHAR_PLUS);
    hit_63 = url_alpha ? (ch == b64d_pkg::CHAR_UNDERSCR) : (ch == b64d_pkg::CHAR_SLASH);
    q_entry.eos    = in_data.end_of_string;
    q_entry.kind   = b64d_pkg::KIND_DATA;
    q_entry.sextet = '0;
    if (ch == b64d_pkg::PAD_CHAR) begin
      q_entry.kind = b64d_pkg::KIND_PAD;
    end else if (ch >= b64d_pkg::CHAR_UPPER_A && ch <= b64d_pkg::CHAR_UPPER_Z) begin
      q_entry.sextet = 6'(ch - b64d_pkg::CHAR_UPPER_A);
    end else if (ch >= b64d_pkg::CHAR_LOWER_A && ch <= b64d_pkg::CHAR_LOWER_Z) begin
      q_entry.sextet = 6'(ch - b64d_pkg::CHAR_LOWER_A) + b64d_pkg::LOWER_BASE;
    end else if (ch >= b64d_pkg::CHAR_DIGIT_0 && ch <= b64d_pkg::CHAR_DIGIT_9) begin
      q_entry.sextet = 6'(ch - b64d_pkg::CHAR_DIGIT_0) + b64d_pkg::DIGIT_BASE;
    end else if (hit_62) begin
      q_entry.sextet = b64d_pkg::SEXTET_62;
    end else if (hit_63) begin
      q_entry.sextet = b64d_pkg::SEXTET_63;
    end else begin
      q_entry.kind = b64d_pkg::KIND_SKIP;
    end
  end

  // tracks whether any beat has been taken since reset
  assign beat_seen_nxt = beat_seen_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_seen_r <= 1'b0;
    end else begin
      beat_seen_r <= beat_seen_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push while queue full");

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !q_full) |-> (q_push && beat_seen_nxt))
    else $error("beat offered with room but not pushed");

  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    beat_seen_r |=> beat_seen_r)
    else $error("beat-seen flag dropped");

endmodule

`default_nettype wire

@@ sv/b64d_fifo.sv @@
`default_nettype none

module b64d_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  b64d_pkg::b64d_entry_t push_data,
  output logic                  full,
  input  wire                   pop,
  output logic                  empty,
  output b64d_pkg::b64d_entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64d_pkg::b64d_entry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/b64d_back.sv @@
`default_nettype none

module b64d_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  b64d_pkg::b64d_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output b64d_pkg::b64d_out_t   out_data
);

  logic [b64d_pkg::SEXTET_W-1:0] bits_r, bits_nxt;
  logic [b64d_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          pad_r, pad_nxt;
  logic                          out_valid_r, out_valid_nxt;
  b64d_pkg::b64d_out_t           out_r, out_nxt;

  logic [b64d_pkg::BUF_W-1:0]    buf_w;
  logic [b64d_pkg::BUF_W-1:0]    mask_w;
  logic [b64d_pkg::CNT_W:0]      sum_w;
  logic [b64d_pkg::CNT_W-1:0]    left_w;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign buf_w  = {bits_r, q_entry.sextet};
  assign sum_w  = {1'b0, cnt_r} + (b64d_pkg::CNT_W + 1)'(b64d_pkg::SEXTET_W);
  assign left_w = b64d_pkg::CNT_W'(sum_w - (b64d_pkg::CNT_W + 1)'(8));
  assign mask_w = (b64d_pkg::BUF_W'(1) << left_w) - b64d_pkg::BUF_W'(1);

  always_comb begin
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    pad_nxt       = pad_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      out_valid_nxt          = 1'b1;
      out_nxt.byte_out       = '0;
      out_nxt.byte_valid     = 1'b0;
      out_nxt.last_of_string = q_entry.eos;
      if (!pad_r) begin
        case (q_entry.kind)
          b64d_pkg::KIND_PAD: begin
            pad_nxt = 1'b1;
          end
          b64d_pkg::KIND_DATA: begin
            if (sum_w >= (b64d_pkg::CNT_W + 1)'(8)) begin
              out_nxt.byte_out   = 8'(buf_w >> left_w);
              out_nxt.byte_valid = 1'b1;
              bits_nxt           = b64d_pkg::SEXTET_W'(buf_w & mask_w);
              cnt_nxt            = left_w;
            end else begin
              bits_nxt = q_entry.sextet;
              cnt_nxt  = b64d_pkg::CNT_W'(sum_w);
            end
          end
          default: begin
          end
        endcase
      end
      if (q_entry.eos) begin
        bits_nxt = '0;
        cnt_nxt  = b64d_pkg::BYTE_BITS;
        pad_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      cnt_r       <= '0;
      pad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bits_r      <= bits_nxt;
      cnt_r       <= cnt_nxt;
      pad_r       <= pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cnt_even: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] == 1'b0) && (cnt_r <= 3'd6))
    else $error("bit count off grid");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.eos) |=> (cnt_r == '0 && bits_r == '0 && !pad_r))
    else $error("state not cleared at end of string");

  a_pad_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && pad_r) |=> !out_r.byte_valid)
    else $error("byte emitted after padding");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.byte_valid) |-> (out_r.byte_out == '0))
    else $error("nonzero byte without valid flag");

endmodule

`default_nettype wire

@@ sv/base64_decoder_core.sv @@
// Channel | Ports                          | Beat on
// in      | in_valid, in_ready, in_data    | in_valid && in_ready
// out     | out_valid, out_ready, out_data | out_valid && out_ready
// cfg     | cfg_we, cfg_wdata              | cfg_we
//
// One character per cycle sustained while the queue is not full; the earliest out beat
// follows the in beat through a queue entry and then the output register.
// The queue (QUEUE_DEPTH entries) lets the classifier keep accepting while out is stalled.
// rst_n is synchronous; it clears the queue, bit buffer, pad flag and alphabet select.
// in_ready drops only when the queue is full.
`default_nettype none

module base64_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  b64d_pkg::b64d_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output b64d_pkg::b64d_out_t  out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata
);

  logic                  url_alpha_r, url_alpha_nxt;
  logic                  q_full, q_empty, q_push, q_pop;
  b64d_pkg::b64d_entry_t push_entry, pop_entry;

  assign url_alpha_nxt = cfg_we ? cfg_wdata : url_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_alpha_r <= 1'b0;
    end else begin
      url_alpha_r <= url_alpha_nxt;
    end
  end

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .url_alpha (url_alpha_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_entry)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
